// ===== design/wgpd_pkg.sv =====
// Shared types and constants for the weighted graph path distance block.
// Holds the command, status and sequencer codes and the store control group.
// No dependencies; compiled first.
package wgpd_pkg;

  localparam int unsigned VERTEX_W    = 6;
  localparam int unsigned VERTEX_SPAN = 64;
  localparam int unsigned VCOUNT_W    = 7;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned DIST_W      = 32;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MAX_EDGES_DEF    = 256;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR       = 2'd0,
    CMD_ADD_EDGE    = 2'd1,
    CMD_PATH_VERTEX = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_EDGE_MISSING = 2'd1,
    ST_STORE_FULL   = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_HEAD,
    S_WALK,
    S_STEP,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic clear;
    logic head_we;
    logic edge_we;
  } store_ctl_t;

endpackage

// ===== design/wgpd_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Depends on wgpd_pkg for the field widths.
interface wgpd_in_if #(
  parameter int unsigned WEIGHT_BITS = wgpd_pkg::WEIGHT_BITS_DEF
);
  import wgpd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              command;
  logic [VERTEX_W-1:0]           src_vertex;
  logic [VERTEX_W-1:0]           dest_vertex;
  logic signed [WEIGHT_BITS-1:0] weight;
  logic [VERTEX_W-1:0]           path_vertex;
  logic                          path_last;

  modport source (
    output valid, command, src_vertex, dest_vertex, weight, path_vertex, path_last,
    input  ready
  );
  modport sink (
    input  valid, command, src_vertex, dest_vertex, weight, path_vertex, path_last,
    output ready
  );
endinterface

interface wgpd_out_if;
  import wgpd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     done_res;
  logic signed [DIST_W-1:0] distance;
  logic [STATUS_W-1:0]      status;

  modport source (
    output valid, done_res, distance, status,
    input  ready
  );
  modport sink (
    input  valid, done_res, distance, status,
    output ready
  );
endinterface

// ===== design/wgpd_store.sv =====
// List head memory with per-vertex valid bits, and the edge entry memory.
// Both memories read synchronously, with registered read data.
// Depends on wgpd_pkg for the store control group.
module wgpd_store #(
  parameter int unsigned VDEPTH = 64,
  parameter int unsigned LINK_W = 9,
  parameter int unsigned EDEPTH = 256,
  parameter int unsigned EDGE_W = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wgpd_pkg::store_ctl_t         ctl_i,
  input  logic [$clog2(VDEPTH)-1:0]    head_raddr_i,
  input  logic [$clog2(VDEPTH)-1:0]    head_waddr_i,
  input  logic [LINK_W-1:0]            head_wlink_i,
  output logic [LINK_W-1:0]            head_link_o,
  input  logic [$clog2(EDEPTH)-1:0]    edge_raddr_i,
  input  logic [$clog2(EDEPTH)-1:0]    edge_waddr_i,
  input  logic [EDGE_W-1:0]            edge_wdata_i,
  output logic [EDGE_W-1:0]            edge_rdata_o
);
  import wgpd_pkg::*;

  logic [LINK_W-1:0] head_mem [VDEPTH];
  logic [EDGE_W-1:0] edge_mem [EDEPTH];
  logic [VDEPTH-1:0] head_valid_q;
  logic [LINK_W-1:0] head_rdata_q;
  logic              head_rvalid_q;
  logic [EDGE_W-1:0] edge_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.head_we) begin
      head_mem[head_waddr_i] <= head_wlink_i;
    end
    head_rdata_q <= head_mem[head_raddr_i];
  end

  // A head that was never written since the last clear reads as an empty list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q  <= '0;
      head_rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        head_valid_q <= '0;
      end else if (ctl_i.head_we) begin
        head_valid_q[head_waddr_i] <= 1'b1;
      end
      head_rvalid_q <= head_valid_q[head_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.edge_we) begin
      edge_mem[edge_waddr_i] <= edge_wdata_i;
    end
    edge_rdata_q <= edge_mem[edge_raddr_i];
  end

  assign head_link_o  = head_rvalid_q ? head_rdata_q : '0;
  assign edge_rdata_o = edge_rdata_q;

endmodule

// ===== design/weighted_graph_path_distance_core.sv =====
// Weighted graph path distance core: per-vertex edge lists in memory, path length sums.
// Per item: clear, unused commands, rejected edges and out-of-range path vertices pass
// through decode and finish only; a stored edge adds the add state; a path vertex adds
// step, after a head read and a walk of one list entry per cycle for a lookup.
// The result shows in the same cycle that the input is ready again; a waiting result stalls it.
// Reset empties every list via the head valid bits, clears the path, sets vertex_count 64.
module weighted_graph_path_distance_core #(
  parameter int unsigned MAX_VERTICES = wgpd_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = wgpd_pkg::MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS  = wgpd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wgpd_in_if.sink                        in_i,
  wgpd_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [wgpd_pkg::VCOUNT_W-1:0]  cfg_wdata_i
);
  import wgpd_pkg::*;

  localparam int unsigned VDEPTH = (MAX_VERTICES < VERTEX_SPAN) ? MAX_VERTICES : VERTEX_SPAN;
  localparam int unsigned VIDX_W = $clog2(VDEPTH);
  localparam int unsigned LINK_W = $clog2(MAX_EDGES + 1);
  localparam int unsigned EIDX_W = $clog2(MAX_EDGES);
  localparam int unsigned EDGE_W = VERTEX_W + WEIGHT_BITS + LINK_W;
  localparam int unsigned SUM_W  = DIST_W + 1;

  localparam logic signed [DIST_W-1:0] DIST_MAX  = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN  = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic signed [DIST_W-1:0] DIST_FAIL = '1;

  state_e state_q, state_d;

  // Accepted item.
  logic [CMD_W-1:0]              cmd_q;
  logic [VERTEX_W-1:0]           src_q;
  logic [VERTEX_W-1:0]           dest_q;
  logic signed [WEIGHT_BITS-1:0] weight_q;
  logic [VERTEX_W-1:0]           pv_q;
  logic                          last_q;

  logic [VCOUNT_W-1:0] vcount_q;
  logic [LINK_W-1:0]   used_q, used_d;

  logic [VERTEX_W-1:0]      prev_q, prev_d;
  logic                     have_prev_q, have_prev_d;
  logic signed [DIST_W-1:0] run_q, run_d;
  logic                     failed_q, failed_d;

  logic                     res_done_q, res_done_d;
  logic signed [DIST_W-1:0] res_dist_q, res_dist_d;
  logic [STATUS_W-1:0]      res_status_q, res_status_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_done_q;
  logic signed [DIST_W-1:0] out_dist_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic                     load_out;

  store_ctl_t          ctl;
  logic [VIDX_W-1:0]   head_raddr, head_waddr;
  logic [LINK_W-1:0]   head_wlink, head_link;
  logic [EIDX_W-1:0]   edge_raddr, edge_waddr;
  logic [EDGE_W-1:0]   edge_wdata, edge_rdata;

  logic                          in_accept;
  logic                          src_ok, dest_ok, pv_ok, store_full, out_free;
  logic [VERTEX_W-1:0]           head_vertex;
  logic [VERTEX_W-1:0]           e_dest;
  logic signed [WEIGHT_BITS-1:0] e_weight;
  logic [LINK_W-1:0]             e_next;
  logic [LINK_W-1:0]             head_link_m1, e_next_m1;
  logic signed [SUM_W-1:0]       sum;
  logic signed [DIST_W-1:0]      sum_sat;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign src_ok  = ({1'b0, src_q} < vcount_q) && (32'(src_q) < MAX_VERTICES);
  assign dest_ok = ({1'b0, dest_q} < vcount_q) && (32'(dest_q) < MAX_VERTICES);
  assign pv_ok   = ({1'b0, pv_q} < vcount_q) && (32'(pv_q) < MAX_VERTICES);
  assign store_full = (used_q == LINK_W'(MAX_EDGES));

  // Edge entry layout: destination, weight, link to the next older entry.
  assign e_dest   = edge_rdata[EDGE_W-1 -: VERTEX_W];
  assign e_weight = edge_rdata[LINK_W +: WEIGHT_BITS];
  assign e_next   = edge_rdata[LINK_W-1:0];

  assign head_link_m1 = head_link - 1'b1;
  assign e_next_m1    = e_next - 1'b1;

  assign head_vertex = (cmd_q == CMD_ADD_EDGE) ? src_q : prev_q;
  assign head_raddr  = head_vertex[VIDX_W-1:0];

  assign sum = SUM_W'(run_q) + SUM_W'(e_weight);
  always_comb begin
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      sum_sat = sum[SUM_W-1] ? DIST_MIN : DIST_MAX;
    end else begin
      sum_sat = sum[DIST_W-1:0];
    end
  end

  wgpd_store #(
    .VDEPTH (VDEPTH),
    .LINK_W (LINK_W),
    .EDEPTH (MAX_EDGES),
    .EDGE_W (EDGE_W)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .head_raddr_i (head_raddr),
    .head_waddr_i (head_waddr),
    .head_wlink_i (head_wlink),
    .head_link_o  (head_link),
    .edge_raddr_i (edge_raddr),
    .edge_waddr_i (edge_waddr),
    .edge_wdata_i (edge_wdata),
    .edge_rdata_o (edge_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_ADD_EDGE: begin
            state_d = (src_ok && dest_ok && !store_full) ? S_ADD : S_FINISH;
          end
          CMD_PATH_VERTEX: begin
            if (!pv_ok) begin
              state_d = S_FINISH;
            end else if (have_prev_q && !failed_q) begin
              state_d = S_HEAD;
            end else begin
              state_d = S_STEP;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_ADD:  state_d = S_FINISH;
      S_HEAD: state_d = (head_link == '0) ? S_STEP : S_WALK;
      S_WALK: begin
        if (e_dest == pv_q || e_next == '0) state_d = S_STEP;
      end
      S_STEP: state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    ctl          = '0;
    head_waddr   = src_q[VIDX_W-1:0];
    head_wlink   = used_q + 1'b1;
    edge_waddr   = used_q[EIDX_W-1:0];
    edge_wdata   = {dest_q, weight_q, head_link};
    edge_raddr   = head_link_m1[EIDX_W-1:0];
    used_d       = used_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    run_d        = run_q;
    failed_d     = failed_q;
    res_done_d   = res_done_q;
    res_dist_d   = res_dist_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    load_out     = 1'b0;
    case (state_q)
      S_DECODE: begin
        res_done_d   = 1'b0;
        res_dist_d   = '0;
        res_status_d = ST_OK;
        case (cmd_q)
          CMD_CLEAR: begin
            ctl.clear   = 1'b1;
            used_d      = '0;
            prev_d      = '0;
            have_prev_d = 1'b0;
            run_d       = '0;
            failed_d    = 1'b0;
          end
          CMD_ADD_EDGE: begin
            if (!(src_ok && dest_ok)) begin
              res_status_d = ST_OUT_OF_RANGE;
            end else if (store_full) begin
              res_status_d = ST_STORE_FULL;
            end
          end
          CMD_PATH_VERTEX: begin
            if (!pv_ok) begin
              res_done_d   = 1'b1;
              res_dist_d   = DIST_FAIL;
              res_status_d = ST_OUT_OF_RANGE;
              prev_d       = '0;
              have_prev_d  = 1'b0;
              run_d        = '0;
              failed_d     = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      S_ADD: begin
        // The new entry points at the old head, so the newest duplicate is met first.
        ctl.head_we = 1'b1;
        ctl.edge_we = 1'b1;
        used_d      = used_q + 1'b1;
      end
      S_HEAD: begin
        edge_raddr = head_link_m1[EIDX_W-1:0];
        if (head_link == '0) failed_d = 1'b1;
      end
      S_WALK: begin
        edge_raddr = e_next_m1[EIDX_W-1:0];
        if (e_dest == pv_q) begin
          run_d = sum_sat;
        end else if (e_next == '0) begin
          failed_d = 1'b1;
        end
      end
      S_STEP: begin
        prev_d      = pv_q;
        have_prev_d = 1'b1;
        if (last_q) begin
          res_done_d   = 1'b1;
          res_dist_d   = failed_q ? DIST_FAIL : run_q;
          res_status_d = failed_q ? ST_EDGE_MISSING : ST_OK;
          prev_d       = '0;
          have_prev_d  = 1'b0;
          run_d        = '0;
          failed_d     = 1'b0;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          load_out    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= VCOUNT_RESET;
      used_q      <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      run_q       <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      used_q      <= used_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      run_q       <= run_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= in_i.command;
      src_q    <= in_i.src_vertex;
      dest_q   <= in_i.dest_vertex;
      weight_q <= in_i.weight;
      pv_q     <= in_i.path_vertex;
      last_q   <= in_i.path_last;
    end
    res_done_q   <= res_done_d;
    res_dist_q   <= res_dist_d;
    res_status_q <= res_status_d;
    if (load_out) begin
      out_done_q   <= res_done_q;
      out_dist_q   <= res_dist_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.done_res = out_done_q;
  assign out_o.distance = out_dist_q;
  assign out_o.status   = out_status_q;

endmodule

// ===== design/wgpd_checker.sv =====
// Port-level checks on the result channel of the path distance core.
// Depends on wgpd_pkg for the status codes; bound to the top level below.
module wgpd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic                                done_res_i,
  input logic signed [wgpd_pkg::DIST_W-1:0]  distance_i,
  input logic [wgpd_pkg::STATUS_W-1:0]       status_i
);
  import wgpd_pkg::*;

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(done_res_i)
      && $stable(distance_i) && $stable(status_i))
    else $error("result item changed while stalled");

  a_missing_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_EDGE_MISSING |-> done_res_i && distance_i == '1)
    else $error("missing edge result without finished path and failure distance");

  a_not_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !done_res_i |-> distance_i == '0)
    else $error("distance non-zero on an item that finished no path");

  a_full_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_STORE_FULL |-> !done_res_i)
    else $error("store full reported on a finished path");

endmodule

bind weighted_graph_path_distance_core wgpd_checker u_wgpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .done_res_i  (out_o.done_res),
  .distance_i  (out_o.distance),
  .status_i    (out_o.status)
);
